/* rtl/dual_port_uart_ring_buffers_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the dual-port serial ring buffer block
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DUAL_PORT_UART_RING_BUFFERS_CORE_MACROS_SVH
`define DUAL_PORT_UART_RING_BUFFERS_CORE_MACROS_SVH

// same-cycle implication
`define URB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define URB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/urb_pkg.sv */
// ----------------------------------------------------------------------------
// urb_pkg
// Shared types and constants of the dual-port serial ring buffer block.
// ----------------------------------------------------------------------------
package urb_pkg;

	// field widths
	localparam int CMD_W      = 3;
	localparam int PORT_W     = 2;
	localparam int BYTE_W     = 8;
	localparam int STATUS_W   = 3;
	localparam int SPACE_W    = 3;
	localparam int RX_SIZE_W  = 5;
	localparam int TX_SIZE_W  = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	// smallest usable ring (one slot always stays empty)
	localparam int MIN_RING = 2;

	// register reset values
	localparam logic [RX_SIZE_W-1:0] RX_SIZE_FIRST_RST  = 5'd8;
	localparam logic [RX_SIZE_W-1:0] RX_SIZE_SECOND_RST = 5'd16;
	localparam logic [TX_SIZE_W-1:0] TX_SIZE_FIRST_RST  = 4'd8;
	localparam logic [TX_SIZE_W-1:0] TX_SIZE_SECOND_RST = 4'd8;

	// request queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_OPEN     = 3'd0,
		CMD_CLOSE    = 3'd1,
		CMD_GET      = 3'd2,
		CMD_PUT      = 3'd3,
		CMD_LINE_RX  = 3'd4,
		CMD_TX_READY = 3'd5
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 3'd0,
		ST_BAD_PORT     = 3'd1,
		ST_ALREADY_OPEN = 3'd2,
		ST_CLOSED       = 3'd3,
		ST_RX_EMPTY     = 3'd4,
		ST_TX_FULL      = 3'd5,
		ST_RX_OVERFLOW  = 3'd6
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RX_SIZE_FIRST  = 2'd0,
		REG_RX_SIZE_SECOND = 2'd1,
		REG_TX_SIZE_FIRST  = 2'd2,
		REG_TX_SIZE_SECOND = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SPACE,
		BK_MOD
	} back_state_t;

	// classified request
	typedef struct packed {
		cmd_t              cmd;
		logic              known;
		logic              port_ok;
		logic [PORT_W-1:0] port;
		logic [BYTE_W-1:0] data;
	} item_t;

	// ring size registers, raw as written
	typedef struct packed {
		logic [RX_SIZE_W-1:0] rx_first;
		logic [RX_SIZE_W-1:0] rx_second;
		logic [TX_SIZE_W-1:0] tx_first;
		logic [TX_SIZE_W-1:0] tx_second;
	} cfg_t;

endpackage

/* rtl/urb_front.sv */
// ----------------------------------------------------------------------------
// urb_front
// Accepts requests, checks the port number and decodes the command.
// ----------------------------------------------------------------------------
module urb_front #(
	parameter int PORT_COUNT = 2
) (
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  logic [urb_pkg::CMD_W-1:0]   command,
	input  logic [urb_pkg::PORT_W-1:0]  port_sel,
	input  logic [urb_pkg::BYTE_W-1:0]  byte_in,
	input  logic                        q_full,
	output logic                        q_push,
	output urb_pkg::item_t              q_item
);
	import urb_pkg::*;

	// accept whenever the queue has a free slot
	assign cmd_ready = !q_full;
	assign q_push    = cmd_valid && !q_full;

	// classify the request
	always_comb begin
		q_item.known   = command inside {CMD_OPEN, CMD_CLOSE, CMD_GET, CMD_PUT,
			CMD_LINE_RX, CMD_TX_READY};
		q_item.cmd     = q_item.known ? cmd_t'(command) : CMD_OPEN;
		q_item.port_ok = 32'(port_sel) < PORT_COUNT;
		q_item.port    = port_sel;
		q_item.data    = byte_in;
	end

endmodule

/* rtl/urb_fifo.sv */
// ----------------------------------------------------------------------------
// urb_fifo
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module urb_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  urb_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output urb_pkg::item_t pop_item
);
	import urb_pkg::*;

	localparam int QW = $clog2(QUEUE_DEPTH);

	item_t          slot_q [QUEUE_DEPTH];
	logic [QW-1:0]  wr_ptr_q;
	logic [QW-1:0]  rd_ptr_q;
	logic [QW:0]    count_q;

	assign full     = count_q == (QW+1)'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign pop_item = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QW'(1);
			if (push && !pop)      count_q <= count_q + (QW+1)'(1);
			else if (pop && !push) count_q <= count_q - (QW+1)'(1);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_item;
	end

endmodule

/* rtl/urb_rem.sv */
// ----------------------------------------------------------------------------
// urb_rem
// Bit-serial remainder of two pointers by the ring size, one bit a cycle.
// ----------------------------------------------------------------------------
module urb_rem #(
	parameter int W  = 3,
	parameter int SW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [W-1:0]  a,
	input  logic [W-1:0]  b,
	input  logic [SW-1:0] d,
	output logic          done,
	output logic [W-1:0]  rem_a,
	output logic [W-1:0]  rem_b
);
	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  a_sh_q;
	logic [W-1:0]  b_sh_q;
	logic [SW:0]   ra_q;
	logic [SW:0]   rb_q;

	// one restoring step: shift in a bit, subtract the divisor if it fits
	function automatic logic [SW:0] rem_step(input logic [SW:0] r, input logic bit_in);
		logic [SW:0] t;
		t = {r[SW-1:0], bit_in};
		if (t >= {1'b0, d}) t = t - {1'b0, d};
		return t;
	endfunction

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			a_sh_q <= a;
			b_sh_q <= b;
			ra_q   <= '0;
			rb_q   <= '0;
		end else if (busy_q) begin
			ra_q   <= rem_step(ra_q, a_sh_q[W-1]);
			rb_q   <= rem_step(rb_q, b_sh_q[W-1]);
			a_sh_q <= a_sh_q << 1;
			b_sh_q <= b_sh_q << 1;
		end
	end

	assign done  = done_q;
	assign rem_a = ra_q[W-1:0];
	assign rem_b = rb_q[W-1:0];

endmodule

/* rtl/urb_back.sv */
// ----------------------------------------------------------------------------
// urb_back
// Executes queued requests on the per-port rings and builds the response.
// ----------------------------------------------------------------------------
module urb_back #(
	parameter int RX_DEPTH   = 16,
	parameter int TX_DEPTH   = 8,
	parameter int PORT_COUNT = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  urb_pkg::cfg_t                 cfg,
	input  logic                          q_empty,
	input  urb_pkg::item_t                q_item,
	output logic                          q_pop,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [urb_pkg::STATUS_W-1:0]  status,
	output logic [urb_pkg::BYTE_W-1:0]    byte_out,
	output logic                          byte_valid,
	output logic [urb_pkg::SPACE_W-1:0]   tx_space,
	output logic                          tx_request,
	output logic                          rx_event,
	output logic                          tx_event
);
	import urb_pkg::*;

	localparam int RPW = $clog2(RX_DEPTH);
	localparam int TPW = $clog2(TX_DEPTH);
	localparam int RSW = $clog2(RX_DEPTH + 1);
	localparam int TSW = $clog2(TX_DEPTH + 1);
	localparam int PIW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
	localparam int RAW = $clog2(PORT_COUNT * RX_DEPTH);
	localparam int TAW = $clog2(PORT_COUNT * TX_DEPTH);

	// ring sizes in use, clamped to MIN_RING and to the storage
	function automatic logic [RSW-1:0] rx_size_of(input logic [PIW-1:0] p);
		logic [RX_SIZE_W-1:0] raw;
		raw = (p == '0) ? cfg.rx_first : cfg.rx_second;
		if (32'(raw) < MIN_RING) return RSW'(MIN_RING);
		if (32'(raw) > RX_DEPTH) return RSW'(RX_DEPTH);
		return RSW'(raw);
	endfunction

	function automatic logic [TSW-1:0] tx_size_of(input logic [PIW-1:0] p);
		logic [TX_SIZE_W-1:0] raw;
		raw = (p == '0) ? cfg.tx_first : cfg.tx_second;
		if (32'(raw) < MIN_RING) return TSW'(MIN_RING);
		if (32'(raw) > TX_DEPTH) return TSW'(TX_DEPTH);
		return TSW'(raw);
	endfunction

	// pointer advance with wrap at the ring size
	function automatic logic [RPW-1:0] rx_adv(input logic [RPW-1:0] ptr,
			input logic [RSW-1:0] size);
		logic [RPW:0] n;
		n = {1'b0, ptr} + (RPW+1)'(1);
		if (n >= (RPW+1)'(size)) return '0;
		return n[RPW-1:0];
	endfunction

	function automatic logic [TPW-1:0] tx_adv(input logic [TPW-1:0] ptr,
			input logic [TSW-1:0] size);
		logic [TPW:0] n;
		n = {1'b0, ptr} + (TPW+1)'(1);
		if (n >= (TPW+1)'(size)) return '0;
		return n[TPW-1:0];
	endfunction

	// flat store addresses
	function automatic logic [RAW-1:0] rx_addr(input logic [PIW-1:0] p,
			input logic [RPW-1:0] ptr);
		return RAW'(p) * RAW'(RX_DEPTH) + RAW'(ptr);
	endfunction

	function automatic logic [TAW-1:0] tx_addr(input logic [PIW-1:0] p,
			input logic [TPW-1:0] ptr);
		return TAW'(p) * TAW'(TX_DEPTH) + TAW'(ptr);
	endfunction

	// per-port state
	logic [RPW-1:0] rx_wptr_q [PORT_COUNT];
	logic [RPW-1:0] rx_rptr_q [PORT_COUNT];
	logic [TPW-1:0] tx_wptr_q [PORT_COUNT];
	logic [TPW-1:0] tx_rptr_q [PORT_COUNT];
	logic           open_q    [PORT_COUNT];
	logic           armed_q   [PORT_COUNT];

	// byte stores
	logic [BYTE_W-1:0] rx_mem [PORT_COUNT * RX_DEPTH];
	logic [BYTE_W-1:0] tx_mem [PORT_COUNT * TX_DEPTH];
	logic [BYTE_W-1:0] rx_rd_q;
	logic [BYTE_W-1:0] tx_rd_q;

	// sequencer
	back_state_t state_q, state_d;
	logic        exec_en;
	logic        rem_start;
	logic        rem_done;
	logic        load_out;
	logic        out_free;
	logic        needs_mod;
	logic        mod_done_q;

	// execute-stage signals
	logic [PIW-1:0] ex_p;
	logic [RSW-1:0] ex_rs;
	logic [TSW-1:0] ex_ts;
	logic [RPW-1:0] cur_rw, cur_rr, nxt_rw, nxt_rr;
	logic [TPW-1:0] cur_tw, cur_tr, nxt_tw, nxt_tr;
	logic           cur_open, cur_armed, nxt_open, nxt_armed;
	logic [RPW-1:0] rx_wn;
	logic [TPW-1:0] tx_wn;
	status_t        ex_status;
	logic           ex_bvalid, ex_src_tx, ex_rxe, ex_txe;
	logic           rx_we, rx_re, tx_we, tx_re;

	// results carried to the response step
	logic [PIW-1:0] port_s1;
	logic           port_ok_s1;
	status_t        status_s1;
	logic           bvalid_s1, src_tx_s1, rxe_s1, txe_s1;

	// response step signals
	logic [TSW-1:0] sp_size;
	logic [TPW-1:0] sp_w, sp_r, sp_h, sp_t;
	logic [TPW-1:0] rem_a, rem_b;
	logic [TSW:0]   sp_sum, sp_free;
	logic           sp_open;

	// output register
	logic                 rsp_valid_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [BYTE_W-1:0]    out_byte_q;
	logic                 out_bvalid_q;
	logic [SPACE_W-1:0]   out_space_q;
	logic                 out_req_q;
	logic                 out_rxe_q;
	logic                 out_txe_q;

	// ---------------------------------------------------------------- execute
	always_comb begin
		ex_p      = q_item.port[PIW-1:0];
		ex_rs     = rx_size_of(ex_p);
		ex_ts     = tx_size_of(ex_p);
		cur_rw    = rx_wptr_q[ex_p];
		cur_rr    = rx_rptr_q[ex_p];
		cur_tw    = tx_wptr_q[ex_p];
		cur_tr    = tx_rptr_q[ex_p];
		cur_open  = open_q[ex_p];
		cur_armed = armed_q[ex_p];
		rx_wn     = rx_adv(cur_rw, ex_rs);
		tx_wn     = tx_adv(cur_tw, ex_ts);

		nxt_rw    = cur_rw;
		nxt_rr    = cur_rr;
		nxt_tw    = cur_tw;
		nxt_tr    = cur_tr;
		nxt_open  = cur_open;
		nxt_armed = cur_armed;
		ex_status = ST_OK;
		ex_bvalid = 1'b0;
		ex_src_tx = 1'b0;
		ex_rxe    = 1'b0;
		ex_txe    = 1'b0;
		rx_we     = 1'b0;
		rx_re     = 1'b0;
		tx_we     = 1'b0;
		tx_re     = 1'b0;

		if (!q_item.port_ok) begin
			ex_status = ST_BAD_PORT;
		end else if (q_item.known) begin
			if (q_item.cmd == CMD_OPEN) begin
				if (cur_open) begin
					ex_status = ST_ALREADY_OPEN;
				end else begin
					nxt_rw    = '0;
					nxt_rr    = '0;
					nxt_tw    = '0;
					nxt_tr    = '0;
					nxt_armed = 1'b0;
					nxt_open  = 1'b1;
				end
			end else if (!cur_open) begin
				ex_status = ST_CLOSED;
			end else begin
				case (q_item.cmd)
					CMD_CLOSE: begin
						nxt_open  = 1'b0;
						nxt_armed = 1'b0;
					end
					CMD_GET: begin
						if (cur_rr != cur_rw) begin
							rx_re     = 1'b1;
							ex_bvalid = 1'b1;
							nxt_rr    = rx_adv(cur_rr, ex_rs);
						end else begin
							ex_status = ST_RX_EMPTY;
						end
					end
					CMD_PUT: begin
						if (tx_wn == cur_tr) begin
							ex_status = ST_TX_FULL;
						end else begin
							tx_we     = 1'b1;
							nxt_tw    = tx_wn;
							nxt_armed = 1'b1;
						end
					end
					CMD_LINE_RX: begin
						ex_rxe = 1'b1;
						if (rx_wn == cur_rr) begin
							ex_status = ST_RX_OVERFLOW;
						end else begin
							rx_we  = 1'b1;
							nxt_rw = rx_wn;
						end
					end
					CMD_TX_READY: begin
						if (cur_armed) begin
							ex_txe = 1'b1;
							if (cur_tr != cur_tw) begin
								tx_re     = 1'b1;
								ex_bvalid = 1'b1;
								ex_src_tx = 1'b1;
								nxt_tr    = tx_adv(cur_tr, ex_ts);
							end else begin
								nxt_armed = 1'b0;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	// port state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PORT_COUNT; i++) begin
				rx_wptr_q[i] <= '0;
				rx_rptr_q[i] <= '0;
				tx_wptr_q[i] <= '0;
				tx_rptr_q[i] <= '0;
				open_q[i]    <= 1'b0;
				armed_q[i]   <= 1'b0;
			end
		end else if (exec_en && q_item.port_ok) begin
			rx_wptr_q[ex_p] <= nxt_rw;
			rx_rptr_q[ex_p] <= nxt_rr;
			tx_wptr_q[ex_p] <= nxt_tw;
			tx_rptr_q[ex_p] <= nxt_tr;
			open_q[ex_p]    <= nxt_open;
			armed_q[ex_p]   <= nxt_armed;
		end
	end

	// receive store, registered read
	always_ff @(posedge clk) begin
		if (exec_en && rx_we) rx_mem[rx_addr(ex_p, cur_rw)] <= q_item.data;
		if (exec_en && rx_re) rx_rd_q <= rx_mem[rx_addr(ex_p, cur_rr)];
	end

	// transmit store, registered read
	always_ff @(posedge clk) begin
		if (exec_en && tx_we) tx_mem[tx_addr(ex_p, cur_tw)] <= q_item.data;
		if (exec_en && tx_re) tx_rd_q <= tx_mem[tx_addr(ex_p, cur_tr)];
	end

	// execute results
	always_ff @(posedge clk) begin
		if (exec_en) begin
			port_s1    <= ex_p;
			port_ok_s1 <= q_item.port_ok;
			status_s1  <= ex_status;
			bvalid_s1  <= ex_bvalid;
			src_tx_s1  <= ex_src_tx;
			rxe_s1     <= ex_rxe;
			txe_s1     <= ex_txe;
		end
	end

	// --------------------------------------------------------- free tx space
	always_comb begin
		sp_size   = tx_size_of(port_s1);
		sp_w      = tx_wptr_q[port_s1];
		sp_r      = tx_rptr_q[port_s1];
		sp_open   = port_ok_s1 && open_q[port_s1];
		// a pointer left beyond a shrunken ring needs a true remainder
		needs_mod = sp_open && ((TSW'(sp_w) >= sp_size) || (TSW'(sp_r) >= sp_size));
		sp_h      = mod_done_q ? rem_a : sp_w;
		sp_t      = mod_done_q ? rem_b : sp_r;
		sp_sum    = (TSW+1)'(sp_t) + (TSW+1)'(sp_size) - (TSW+1)'(sp_h) - (TSW+1)'(1);
		sp_free   = (sp_sum >= (TSW+1)'(sp_size)) ? sp_sum - (TSW+1)'(sp_size) : sp_sum;
	end

	urb_rem #(
		.W  (TPW),
		.SW (TSW)
	) u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rem_start),
		.a      (sp_w),
		.b      (sp_r),
		.d      (sp_size),
		.done   (rem_done),
		.rem_a  (rem_a),
		.rem_b  (rem_b)
	);

	// ------------------------------------------------------------- sequencer
	assign out_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) state_d = BK_SPACE;
			end
			BK_SPACE: begin
				if (needs_mod && !mod_done_q) state_d = BK_MOD;
				else if (out_free)            state_d = BK_IDLE;
			end
			BK_MOD: begin
				if (rem_done) state_d = BK_SPACE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		exec_en   = 1'b0;
		rem_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			BK_IDLE: begin
				exec_en = !q_empty;
			end
			BK_SPACE: begin
				rem_start = needs_mod && !mod_done_q;
				load_out  = !(needs_mod && !mod_done_q) && out_free;
			end
			default: ;
		endcase
	end

	assign q_pop = exec_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			mod_done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rem_done)      mod_done_q <= 1'b1;
			else if (load_out) mod_done_q <= 1'b0;
		end
	end

	// ------------------------------------------------------- response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= status_s1;
			out_bvalid_q <= bvalid_s1;
			out_byte_q   <= !bvalid_s1 ? '0 : (src_tx_s1 ? tx_rd_q : rx_rd_q);
			out_space_q  <= sp_open ? SPACE_W'(sp_free) : '0;
			out_req_q    <= port_ok_s1 && armed_q[port_s1];
			out_rxe_q    <= rxe_s1;
			out_txe_q    <= txe_s1;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = out_status_q;
	assign byte_out   = out_byte_q;
	assign byte_valid = out_bvalid_q;
	assign tx_space   = out_space_q;
	assign tx_request = out_req_q;
	assign rx_event   = out_rxe_q;
	assign tx_event   = out_txe_q;

endmodule

/* rtl/dual_port_uart_ring_buffers_core.sv */
// Serial ring buffers for PORT_COUNT ports, each with a receive ring and a
// transmit ring whose sizes are set by four registers (a ring of size N holds
// N-1 bytes). Requests enter a two-entry queue, so cmd_ready stays high while
// the queue has room; the back end handles one request at a time, updating
// the rings and reading the store in BK_IDLE, then building the response in
// BK_SPACE, where it waits while the output register is full. When a transmit
// pointer lies beyond a ring that was made smaller while open, the free-space
// figure goes through a bit-serial remainder unit (state BK_MOD) before the
// response is built. The response sits in an output register until taken; a
// new result waits there only for that register.
// Size registers may be written at any time (cfg_ready is always high) but
// are meant to change only while the block is idle.
// ----------------------------------------------------------------------------
// dual_port_uart_ring_buffers_core
// Top level: configuration registers, request front, queue and ring back end.
// ----------------------------------------------------------------------------
module dual_port_uart_ring_buffers_core #(
	parameter int RX_DEPTH   = 16,
	parameter int TX_DEPTH   = 8,
	parameter int PORT_COUNT = 2
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [urb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [urb_pkg::CFG_DATA_W-1:0]  cfg_data,
	// requests
	input  logic                            cmd_valid,
	output logic                            cmd_ready,
	input  logic [urb_pkg::CMD_W-1:0]       command,
	input  logic [urb_pkg::PORT_W-1:0]      port_sel,
	input  logic [urb_pkg::BYTE_W-1:0]      byte_in,
	// responses
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output logic [urb_pkg::STATUS_W-1:0]    status,
	output logic [urb_pkg::BYTE_W-1:0]      byte_out,
	output logic                            byte_valid,
	output logic [urb_pkg::SPACE_W-1:0]     tx_space,
	output logic                            tx_request,
	output logic                            rx_event,
	output logic                            tx_event
);
	import urb_pkg::*;

	cfg_t  cfg_q;
	logic  q_full, q_empty, q_push, q_pop;
	item_t front_item, back_item;

	// size registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rx_first  <= RX_SIZE_FIRST_RST;
			cfg_q.rx_second <= RX_SIZE_SECOND_RST;
			cfg_q.tx_first  <= TX_SIZE_FIRST_RST;
			cfg_q.tx_second <= TX_SIZE_SECOND_RST;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_RX_SIZE_FIRST:  cfg_q.rx_first  <= cfg_data[RX_SIZE_W-1:0];
				REG_RX_SIZE_SECOND: cfg_q.rx_second <= cfg_data[RX_SIZE_W-1:0];
				REG_TX_SIZE_FIRST:  cfg_q.tx_first  <= cfg_data[TX_SIZE_W-1:0];
				REG_TX_SIZE_SECOND: cfg_q.tx_second <= cfg_data[TX_SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// request decode
	urb_front #(
		.PORT_COUNT (PORT_COUNT)
	) u_front (
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.command   (command),
		.port_sel  (port_sel),
		.byte_in   (byte_in),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (front_item)
	);

	// request queue
	urb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (front_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.pop_item  (back_item)
	);

	// ring execution
	urb_back #(
		.RX_DEPTH   (RX_DEPTH),
		.TX_DEPTH   (TX_DEPTH),
		.PORT_COUNT (PORT_COUNT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_empty    (q_empty),
		.q_item     (back_item),
		.q_pop      (q_pop),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.status     (status),
		.byte_out   (byte_out),
		.byte_valid (byte_valid),
		.tx_space   (tx_space),
		.tx_request (tx_request),
		.rx_event   (rx_event),
		.tx_event   (tx_event)
	);

endmodule

/* rtl/urb_chk.sv */
// ----------------------------------------------------------------------------
// urb_chk
// Port-level checks of the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "dual_port_uart_ring_buffers_core_macros.svh"

module urb_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [urb_pkg::STATUS_W-1:0]  status,
	input logic [urb_pkg::BYTE_W-1:0]    byte_out,
	input logic                          byte_valid,
	input logic [urb_pkg::SPACE_W-1:0]   tx_space,
	input logic                          tx_request,
	input logic                          rx_event,
	input logic                          tx_event
);
	import urb_pkg::*;

	// a stalled response holds
	`URB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(byte_out) && $stable(tx_space), "response changed while stalled")

	// a popped byte only comes with an ok status
	`URB_ASSERT_NOW(a_byte_ok, rsp_valid && byte_valid, status == ST_OK, "byte delivered with error status")

	// a bad port leaves every other field quiet
	`URB_ASSERT_NOW(a_bad_port, rsp_valid && status == ST_BAD_PORT, !byte_valid && !tx_request && tx_space == '0 && !rx_event && !tx_event, "bad port response not quiet")

	// a handled tick keeps the request armed exactly when a byte went out
	`URB_ASSERT_NOW(a_tick_req, rsp_valid && tx_event, tx_request == byte_valid, "transmit request inconsistent with tick")

	// a line byte is stored or flagged as overflow
	`URB_ASSERT_NOW(a_rx_evt, rsp_valid && rx_event, status == ST_OK || status == ST_RX_OVERFLOW, "receive event with wrong status")

endmodule

bind dual_port_uart_ring_buffers_core urb_chk u_urb_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp_valid),
	.rsp_ready  (rsp_ready),
	.status     (status),
	.byte_out   (byte_out),
	.byte_valid (byte_valid),
	.tx_space   (tx_space),
	.tx_request (tx_request),
	.rx_event   (rx_event),
	.tx_event   (tx_event)
);

/* tb/dual_port_uart_ring_buffers_core_tb.sv */
// ----------------------------------------------------------------------------
// dual_port_uart_ring_buffers_core_tb
// Self-checking bench for the dual-port serial ring buffers. Requests go in
// over the valid/ready channel and are mirrored by an in-bench ring
// predictor. Each response is compared field by field against the oldest
// prediction. Directed checks cover closed ports, bad ports, reserved
// commands, full and empty rings, and resizing a ring while its port is open.
// Random traffic then runs under several ring sizes and back-pressure mixes.
// ----------------------------------------------------------------------------
module dual_port_uart_ring_buffers_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import urb_pkg::*;

	localparam int RX_DEPTH = 16;
	localparam int TX_DEPTH = 8;
	localparam int PORTS    = 2;

	// command codes outside the defined set
	localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

	localparam int IDLE_LIGHT     = 29;
	localparam int IDLE_HEAVY     = 54;
	localparam int PHASE_REQS     = 65;
	localparam int NUM_PHASES     = 6;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_TAIL     = 16;

	typedef struct packed {
		status_t              status;
		logic [BYTE_W-1:0]    byte_out;
		logic                 byte_valid;
		logic [SPACE_W-1:0]   tx_space;
		logic                 tx_request;
		logic                 rx_event;
		logic                 tx_event;
	} ring_rsp_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  cfg_valid  = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;
	logic                  cmd_valid  = 1'b0;
	logic                  cmd_ready;
	logic [CMD_W-1:0]      command    = '0;
	logic [PORT_W-1:0]     port_sel   = '0;
	logic [BYTE_W-1:0]     byte_in    = '0;
	logic                  rsp_valid;
	logic                  rsp_ready  = 1'b0;
	logic [STATUS_W-1:0]   status;
	logic [BYTE_W-1:0]     byte_out;
	logic                  byte_valid;
	logic [SPACE_W-1:0]    tx_space;
	logic                  tx_request;
	logic                  rx_event;
	logic                  tx_event;

	dual_port_uart_ring_buffers_core #(
		.RX_DEPTH   (RX_DEPTH),
		.TX_DEPTH   (TX_DEPTH),
		.PORT_COUNT (PORTS)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.command    (command),
		.port_sel   (port_sel),
		.byte_in    (byte_in),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.status     (status),
		.byte_out   (byte_out),
		.byte_valid (byte_valid),
		.tx_space   (tx_space),
		.tx_request (tx_request),
		.rx_event   (rx_event),
		.tx_event   (tx_event)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state: raw size registers, ring pointers, port flags, stores
	cfg_t          size_regs = {RX_SIZE_FIRST_RST, RX_SIZE_SECOND_RST,
	                            TX_SIZE_FIRST_RST, TX_SIZE_SECOND_RST};
	bit [3:0]      rx_wr [PORTS];
	bit [3:0]      rx_rd [PORTS];
	bit [2:0]      tx_wr [PORTS];
	bit [2:0]      tx_rd [PORTS];
	bit            is_open [PORTS];
	bit            tx_armed [PORTS];
	bit [7:0]      rx_mem [PORTS*RX_DEPTH];
	bit [7:0]      tx_mem [PORTS*TX_DEPTH];
	// slots written at least once since reset
	bit            rx_filled [PORTS*RX_DEPTH];
	bit            tx_filled [PORTS*TX_DEPTH];

	ring_rsp_t     rsp_due [$];
	int            fail_count    = 0;
	int            send_idle_pct = IDLE_LIGHT;
	int            recv_idle_pct = IDLE_HEAVY;
	int            quiet_cycles  = 0;

	function automatic int clamp_ring(int raw, int depth);
		return (raw < MIN_RING) ? MIN_RING : ((raw > depth) ? depth : raw);
	endfunction

	function automatic int rx_ring_size(int p);
		return clamp_ring((p == 0) ? size_regs.rx_first : size_regs.rx_second, RX_DEPTH);
	endfunction

	function automatic int tx_ring_size(int p);
		return clamp_ring((p == 0) ? size_regs.tx_first : size_regs.tx_second, TX_DEPTH);
	endfunction

	// pointer advance with wrap at the ring size in use
	function automatic int bump(int ptr, int size);
		return (ptr + 1 >= size) ? 0 : ptr + 1;
	endfunction

	// free transmit slots; pointers taken modulo the current size
	function automatic int tx_free(int p);
		int s;
		int h;
		int t;
		s = tx_ring_size(p);
		h = int'(tx_wr[p]) % s;
		t = int'(tx_rd[p]) % s;
		return (t + s - h - 1) % s;
	endfunction

	// predicted response of one request; updates the ring state
	function automatic ring_rsp_t ring_step(logic [CMD_W-1:0] cmd, logic [PORT_W-1:0] p,
			logic [BYTE_W-1:0] b);
		ring_rsp_t r;
		int        nxt;
		int        slot;
		r = '0;
		r.status = ST_OK;
		if (p >= PORTS) begin
			r.status = ST_BAD_PORT;
		end else if (cmd == CMD_OPEN) begin
			if (is_open[p]) begin
				r.status = ST_ALREADY_OPEN;
			end else begin
				rx_wr[p] = '0;
				rx_rd[p] = '0;
				tx_wr[p] = '0;
				tx_rd[p] = '0;
				tx_armed[p] = 1'b0;
				is_open[p] = 1'b1;
			end
		end else if (cmd <= CMD_TX_READY && !is_open[p]) begin
			r.status = ST_CLOSED;
		end else begin
			case (cmd)
				CMD_CLOSE: begin
					is_open[p] = 1'b0;
					tx_armed[p] = 1'b0;
				end
				CMD_GET: begin
					if (rx_rd[p] != rx_wr[p]) begin
						slot = int'(p) * RX_DEPTH + int'(rx_rd[p]);
						r.byte_out = rx_mem[slot];
						r.byte_valid = 1'b1;
						rx_rd[p] = 4'(bump(rx_rd[p], rx_ring_size(p)));
					end else begin
						r.status = ST_RX_EMPTY;
					end
				end
				CMD_PUT: begin
					nxt = bump(tx_wr[p], tx_ring_size(p));
					if (nxt == tx_rd[p]) begin
						r.status = ST_TX_FULL;
					end else begin
						slot = int'(p) * TX_DEPTH + int'(tx_wr[p]);
						tx_mem[slot] = b;
						tx_filled[slot] = 1'b1;
						tx_wr[p] = 3'(nxt);
						tx_armed[p] = 1'b1;
					end
				end
				CMD_LINE_RX: begin
					nxt = bump(rx_wr[p], rx_ring_size(p));
					r.rx_event = 1'b1;
					// overflow drops the byte
					if (nxt == rx_rd[p]) begin
						r.status = ST_RX_OVERFLOW;
					end else begin
						slot = int'(p) * RX_DEPTH + int'(rx_wr[p]);
						rx_mem[slot] = b;
						rx_filled[slot] = 1'b1;
						rx_wr[p] = 4'(nxt);
					end
				end
				CMD_TX_READY: begin
					// tick without an armed request is ignored
					if (tx_armed[p]) begin
						r.tx_event = 1'b1;
						if (tx_rd[p] != tx_wr[p]) begin
							slot = int'(p) * TX_DEPTH + int'(tx_rd[p]);
							r.byte_out = tx_mem[slot];
							r.byte_valid = 1'b1;
							tx_rd[p] = 3'(bump(tx_rd[p], tx_ring_size(p)));
						end else begin
							tx_armed[p] = 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
		if (p < PORTS) begin
			r.tx_request = tx_armed[p];
			if (is_open[p])
				r.tx_space = SPACE_W'(tx_free(p));
		end
		return r;
	endfunction

	// true when the request would pop a slot never written since reset
	function automatic bit would_read_blank(logic [CMD_W-1:0] cmd, logic [PORT_W-1:0] p);
		if (!is_open[p])
			return 1'b0;
		if (cmd == CMD_GET)
			return rx_rd[p] != rx_wr[p] &&
				!rx_filled[int'(p) * RX_DEPTH + int'(rx_rd[p])];
		if (cmd == CMD_TX_READY)
			return tx_armed[p] && tx_rd[p] != tx_wr[p] &&
				!tx_filled[int'(p) * TX_DEPTH + int'(tx_rd[p])];
		return 1'b0;
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// response side back-pressure
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// compare each taken response with the oldest prediction
	always @(posedge clk) begin : rsp_check
		ring_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (rsp_due.size() == 0) begin
				$error("response with no request outstanding");
				fail_count++;
			end else begin
				want = rsp_due.pop_front();
				check_field("status", want.status, status);
				check_field("byte_out", want.byte_out, byte_out);
				check_field("byte_valid", want.byte_valid, byte_valid);
				check_field("tx_space", want.tx_space, tx_space);
				check_field("tx_request", want.tx_request, tx_request);
				check_field("rx_event", want.rx_event, rx_event);
				check_field("tx_event", want.tx_event, tx_event);
			end
		end
	end

	// watchdog: cycles with no handshake on any channel
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// one request; valid stays high afterwards unless a gap follows
	task automatic send_req(logic [CMD_W-1:0] cmd, logic [PORT_W-1:0] p,
			logic [BYTE_W-1:0] b);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		command   <= cmd;
		port_sel  <= p;
		byte_in   <= b;
		do @(posedge clk); while (!cmd_ready);
		rsp_due.push_back(ring_step(cmd, p, b));
	endtask

	// stop sending and wait for every outstanding response
	task automatic drain_responses();
		cmd_valid <= 1'b0;
		while (rsp_due.size() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_RX_SIZE_FIRST:  size_regs.rx_first  = data[RX_SIZE_W-1:0];
			REG_RX_SIZE_SECOND: size_regs.rx_second = data[RX_SIZE_W-1:0];
			REG_TX_SIZE_FIRST:  size_regs.tx_first  = data[TX_SIZE_W-1:0];
			REG_TX_SIZE_SECOND: size_regs.tx_second = data[TX_SIZE_W-1:0];
			default: begin
			end
		endcase
	endtask

	// all four ring sizes back to back; call only with nothing outstanding
	task automatic set_sizes(logic [CFG_DATA_W-1:0] rx0, logic [CFG_DATA_W-1:0] rx1,
			logic [CFG_DATA_W-1:0] tx0, logic [CFG_DATA_W-1:0] tx1);
		cfg_write(REG_RX_SIZE_FIRST, rx0);
		cfg_write(REG_RX_SIZE_SECOND, rx1);
		cfg_write(REG_TX_SIZE_FIRST, tx0);
		cfg_write(REG_TX_SIZE_SECOND, tx1);
		cfg_valid <= 1'b0;
	endtask

	// closed ports, bad ports and reserved commands under reset sizes
	task automatic test_closed_ports();
		send_req(CMD_GET, 0, 8'h00);
		send_req(CMD_CLOSE, 1, 8'h00);
		send_req(CMD_LINE_RX, 0, 8'hFF);
		send_req(CMD_OPEN, 2, 8'h00);
		send_req(CMD_RSVD_LO, 0, 8'h00);
		send_req(CMD_RSVD_HI, 3, 8'h5A);
	endtask

	// smallest rings on port zero: full, empty, overflow, disarm, ignored tick
	task automatic test_small_rings();
		drain_responses();
		// raw 1 and 18 both land on the minimum size
		set_sizes(5'd1, 5'd31, 5'd18, 5'd15);
		send_req(CMD_OPEN, 0, 8'h00);
		send_req(CMD_OPEN, 0, 8'h00);
		send_req(CMD_LINE_RX, 0, 8'hFF);
		send_req(CMD_LINE_RX, 0, 8'h55);
		send_req(CMD_GET, 0, 8'h00);
		send_req(CMD_GET, 0, 8'h00);
		send_req(CMD_PUT, 0, 8'h00);
		send_req(CMD_PUT, 0, 8'hAA);
		send_req(CMD_TX_READY, 0, 8'h00);
		send_req(CMD_TX_READY, 0, 8'h00);
		send_req(CMD_TX_READY, 0, 8'h00);
		send_req(CMD_CLOSE, 0, 8'h00);
	endtask

	// shrink port one's rings while pointers sit beyond the new size
	task automatic test_resize_while_open();
		send_req(CMD_OPEN, 1, 8'h00);
		send_req(CMD_PUT, 1, 8'h11);
		send_req(CMD_PUT, 1, 8'h22);
		send_req(CMD_PUT, 1, 8'h33);
		send_req(CMD_LINE_RX, 1, 8'h80);
		send_req(CMD_LINE_RX, 1, 8'h7F);
		drain_responses();
		set_sizes(5'd1, 5'd2, 5'd18, 5'd2);
		send_req(CMD_TX_READY, 1, 8'h00);
		send_req(CMD_PUT, 1, 8'hC3);
		send_req(CMD_GET, 1, 8'h00);
	endtask

	// one random request, biased toward open ports and ring traffic
	task automatic random_req(output bit counted);
		logic [CMD_W-1:0]  cmd;
		logic [PORT_W-1:0] p;
		int                pick;
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			p   = PORT_W'($urandom_range(PORTS, (1 << PORT_W) - 1));
			cmd = CMD_W'($urandom_range(0, (1 << CMD_W) - 1));
		end else begin
			p = PORT_W'($urandom_range(0, PORTS - 1));
			if (!is_open[p] && $urandom_range(0, 99) < 85)
				cmd = CMD_OPEN;
			else if (pick < 7)
				cmd = CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
			else if (pick < 10)
				cmd = CMD_CLOSE;
			else if (pick < 12)
				cmd = CMD_OPEN;
			else
				cmd = CMD_W'($urandom_range(CMD_GET, CMD_TX_READY));
			if (would_read_blank(cmd, p))
				cmd = CMD_LINE_RX;
		end
		counted = (p < PORTS) && (cmd <= CMD_TX_READY);
		send_req(cmd, p, BYTE_W'($urandom_range(0, (1 << BYTE_W) - 1)));
	endtask

	// random traffic over several size settings and idle mixes
	task automatic test_random_traffic();
		int done;
		int tries;
		bit counted;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain_responses();
			case (ph)
				0:       set_sizes(5'd31, 5'd31, 5'd31, 5'd31);
				1:       set_sizes(5'd0, 5'd1, 5'd16, 5'd17);
				default: set_sizes(CFG_DATA_W'($urandom_range(0, 31)),
				                   CFG_DATA_W'($urandom_range(0, 31)),
				                   CFG_DATA_W'($urandom_range(0, 31)),
				                   CFG_DATA_W'($urandom_range(0, 31)));
			endcase
			if (ph < 2) begin
				send_idle_pct = IDLE_LIGHT;
				recv_idle_pct = IDLE_HEAVY;
			end else if (ph < 4) begin
				send_idle_pct = IDLE_HEAVY;
				recv_idle_pct = IDLE_LIGHT;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			done  = 0;
			tries = 0;
			while (done < PHASE_REQS) begin
				// hold off mid-phase until the block has answered everything
				if (tries == PHASE_REQS / 2)
					drain_responses();
				random_req(counted);
				if (counted)
					done++;
				tries++;
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_closed_ports();
		test_small_rings();
		test_resize_while_open();
		test_random_traffic();
		drain_responses();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
